>>> design/sdspi_pkg.sv
// ----------------------------------------------------------------------------
// sdspi_pkg
// Shared types and constants for the SD card SPI-mode host sequencer.
// ----------------------------------------------------------------------------
package sdspi_pkg;

  // block geometry
  localparam int SECTOR_BYTES   = 512;
  localparam int RESPONSE_POLLS = 9;
  localparam int WAKE_BYTES     = 10;

  localparam int SECTOR_SHIFT = $clog2(SECTOR_BYTES);
  localparam int BC_W         = $clog2(SECTOR_BYTES + 1);

  // field widths
  localparam int SECTOR_W = 23;
  localparam int ADDR_W   = 32;
  localparam int RETRY_W  = 16;
  localparam int CMD_W    = 6;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_INIT_RETRY  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TOKEN_WAIT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BUSY_WAIT   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_START_TOKEN = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ACCEPT_CODE = 3'd4;

  // item kinds
  localparam logic [1:0] KIND_INIT  = 2'd0;
  localparam logic [1:0] KIND_READ  = 2'd1;
  localparam logic [1:0] KIND_WRITE = 2'd2;
  localparam logic [1:0] KIND_XCHG  = 2'd3;

  // pending operation codes
  localparam logic [1:0] OP_NONE  = 2'd0;
  localparam logic [1:0] OP_INIT  = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;
  localparam logic [1:0] OP_WRITE = 2'd3;

  // card commands
  localparam logic [CMD_W-1:0] CMD_GO_IDLE    = 6'd0;
  localparam logic [CMD_W-1:0] CMD_SEND_OP    = 6'd1;
  localparam logic [CMD_W-1:0] CMD_READ_SECT  = 6'd17;
  localparam logic [CMD_W-1:0] CMD_WRITE_SECT = 6'd24;

  // completion status codes
  localparam logic [2:0] ST_OK            = 3'd0;
  localparam logic [2:0] ST_NOT_IDLE      = 3'd1;
  localparam logic [2:0] ST_INIT_TIMEOUT  = 3'd2;
  localparam logic [2:0] ST_CMD_REJECTED  = 3'd3;
  localparam logic [2:0] ST_TOKEN_TIMEOUT = 3'd4;
  localparam logic [2:0] ST_DATA_REJECTED = 3'd5;
  localparam logic [2:0] ST_BUSY_TIMEOUT  = 3'd6;

  // bus byte values
  localparam logic [7:0] CMD_PREFIX = 8'h40;
  localparam logic [7:0] FRAME_CRC  = 8'h95;
  localparam logic [7:0] IDLE_BYTE  = 8'hFF;
  localparam logic [7:0] R1_IDLE    = 8'h01;

  // sequencer phases
  typedef enum logic [3:0] {
    PH_IDLE   = 4'd0,
    PH_WAKE   = 4'd1,
    PH_FRAME  = 4'd2,
    PH_POLL   = 4'd3,
    PH_TOKEN  = 4'd4,
    PH_RDATA  = 4'd5,
    PH_RCRC   = 4'd6,
    PH_WTOKEN = 4'd7,
    PH_WDATA  = 4'd8,
    PH_WCRC   = 4'd9,
    PH_WRESP  = 4'd10,
    PH_WBUSY  = 4'd11,
    PH_DESEL  = 4'd12,
    PH_NEXT   = 4'd13
  } phase_t;

endpackage

>>> design/sd_card_spi_host_sequencer_core.sv
// ----------------------------------------------------------------------------
// sd_card_spi_host_sequencer_core
// Host-side SD card SPI-mode sequencer: init, read-sector and write-sector
// requests and per-byte exchange updates, one result per item.
// ----------------------------------------------------------------------------
// result: each item's result is registered in the output register as its input is taken
// throughput: one item per cycle unless m_tready stalls the output; the phase update
//   is a single pass of logic between the sequencer state and the result register
// reset: rst clears the phase to idle, counters and address to zero, the
//   held response to 0xFF, config registers to their defaults, output empty
module sd_card_spi_host_sequencer_core (
  input  logic        clk,
  input  logic        rst,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // sector[22:0], rx_byte[30:23], write_byte[38:31], zero
  input  logic [1:0]  s_tuser,   // kind[1:0]
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // tx_byte[7:0], tx_valid[8], card_selected[9],
                                 // fast_clock[10], read_byte[18:11], read_valid[19],
                                 // done_res[20], status[23:21], response_code[31:24]
  // configuration write port
  input  logic                            cfg_we,
  input  logic [sdspi_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sdspi_pkg::CFG_DATA_W-1:0] cfg_data
);

  // configuration registers
  logic [sdspi_pkg::RETRY_W-1:0] init_retry_limit;
  logic [sdspi_pkg::RETRY_W-1:0] token_wait_limit;
  logic [sdspi_pkg::RETRY_W-1:0] busy_wait_limit;
  logic [7:0]                    start_token;
  logic [3:0]                    accept_code;

  // sequencer state
  sdspi_pkg::phase_t              phase, phase_next;
  logic [sdspi_pkg::BC_W-1:0]     byte_count, byte_count_next;
  logic [sdspi_pkg::RETRY_W-1:0]  retry_count, retry_count_next;
  logic [sdspi_pkg::ADDR_W-1:0]   card_address, card_address_next;
  logic [sdspi_pkg::CMD_W-1:0]    command_code, command_code_next;
  logic [7:0]                     last_response, last_response_next;
  logic                           fast_mode, fast_mode_next;
  logic [1:0]                     pending_op, pending_op_next;

  // input fields
  logic [1:0]                     kind;
  logic [sdspi_pkg::SECTOR_W-1:0] sector;
  logic [7:0]                     rx_byte;
  logic [7:0]                     write_byte;

  // result fields
  logic [7:0] tx_byte;
  logic       tx_valid;
  logic       card_selected;
  logic [7:0] read_byte;
  logic       read_valid;
  logic       done_res;
  logic [2:0] status;
  logic       active;

  logic [sdspi_pkg::BC_W-1:0]    bc_inc;
  logic [sdspi_pkg::RETRY_W-1:0] retry_inc;
  logic                          in_xfer;

  assign kind       = s_tuser;
  assign sector     = s_tdata[22:0];
  assign rx_byte    = s_tdata[30:23];
  assign write_byte = s_tdata[38:31];

  assign s_tready = !m_tvalid || m_tready;
  assign in_xfer  = s_tvalid && s_tready;

  assign bc_inc    = byte_count + sdspi_pkg::BC_W'(1);
  assign retry_inc = retry_count + sdspi_pkg::RETRY_W'(1);

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      init_retry_limit <= 16'd10000;
      token_wait_limit <= 16'd10000;
      busy_wait_limit  <= 16'hFFFF;
      start_token      <= 8'hFE;
      accept_code      <= 4'h5;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sdspi_pkg::CFG_INIT_RETRY:  init_retry_limit <= cfg_data;
        sdspi_pkg::CFG_TOKEN_WAIT:  token_wait_limit <= cfg_data;
        sdspi_pkg::CFG_BUSY_WAIT:   busy_wait_limit  <= cfg_data;
        sdspi_pkg::CFG_START_TOKEN: start_token      <= cfg_data[7:0];
        sdspi_pkg::CFG_ACCEPT_CODE: accept_code      <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // next state for one item
  always_comb begin
    phase_next         = phase;
    byte_count_next    = byte_count;
    retry_count_next   = retry_count;
    card_address_next  = card_address;
    command_code_next  = command_code;
    last_response_next = last_response;
    fast_mode_next     = fast_mode;
    pending_op_next    = pending_op;
    active             = 1'b0;
    read_byte          = 8'h00;
    read_valid         = 1'b0;
    done_res           = 1'b0;
    status             = sdspi_pkg::ST_OK;

    if (kind != sdspi_pkg::KIND_XCHG) begin
      // new request, started only while idle; otherwise it is accepted and ignored
      if (phase == sdspi_pkg::PH_IDLE) begin
        active             = 1'b1;
        retry_count_next   = '0;
        last_response_next = sdspi_pkg::IDLE_BYTE;
        byte_count_next    = '0;
        if (kind == sdspi_pkg::KIND_INIT) begin
          pending_op_next   = sdspi_pkg::OP_INIT;
          fast_mode_next    = 1'b0;
          card_address_next = '0;
          phase_next        = sdspi_pkg::PH_WAKE;
        end else begin
          card_address_next = {sector, sdspi_pkg::SECTOR_SHIFT'(0)};
          phase_next        = sdspi_pkg::PH_FRAME;
          if (kind == sdspi_pkg::KIND_READ) begin
            pending_op_next   = sdspi_pkg::OP_READ;
            command_code_next = sdspi_pkg::CMD_READ_SECT;
          end else begin
            pending_op_next   = sdspi_pkg::OP_WRITE;
            command_code_next = sdspi_pkg::CMD_WRITE_SECT;
          end
        end
      end
    end else if (phase != sdspi_pkg::PH_IDLE) begin
      active = 1'b1;
      unique case (phase)
        sdspi_pkg::PH_WAKE: begin
          byte_count_next = bc_inc;
          if (bc_inc >= sdspi_pkg::BC_W'(sdspi_pkg::WAKE_BYTES + 1)) begin
            command_code_next = sdspi_pkg::CMD_GO_IDLE;
            phase_next        = sdspi_pkg::PH_FRAME;
            byte_count_next   = '0;
          end
        end
        sdspi_pkg::PH_FRAME: begin
          byte_count_next = bc_inc;
          if (bc_inc >= sdspi_pkg::BC_W'(6)) begin
            phase_next      = sdspi_pkg::PH_POLL;
            byte_count_next = '0;
          end
        end
        sdspi_pkg::PH_POLL: begin
          last_response_next = rx_byte;
          byte_count_next    = bc_inc;
          if (rx_byte != sdspi_pkg::IDLE_BYTE ||
              bc_inc >= sdspi_pkg::BC_W'(sdspi_pkg::RESPONSE_POLLS)) begin
            // response decode per command
            priority if (command_code == sdspi_pkg::CMD_GO_IDLE) begin
              if (rx_byte != sdspi_pkg::R1_IDLE) begin
                phase_next      = sdspi_pkg::PH_DESEL;
                byte_count_next = sdspi_pkg::BC_W'(sdspi_pkg::ST_NOT_IDLE);
              end else begin
                phase_next = sdspi_pkg::PH_NEXT;
              end
            end else if (command_code == sdspi_pkg::CMD_SEND_OP) begin
              retry_count_next = retry_inc;
              if (rx_byte == 8'h00) begin
                phase_next      = sdspi_pkg::PH_DESEL;
                byte_count_next = sdspi_pkg::BC_W'(sdspi_pkg::ST_OK);
              end else if (retry_inc >= init_retry_limit) begin
                phase_next      = sdspi_pkg::PH_DESEL;
                byte_count_next = sdspi_pkg::BC_W'(sdspi_pkg::ST_INIT_TIMEOUT);
              end else begin
                phase_next = sdspi_pkg::PH_NEXT;
              end
            end else if (command_code == sdspi_pkg::CMD_READ_SECT) begin
              if (rx_byte == 8'h00) begin
                phase_next       = sdspi_pkg::PH_TOKEN;
                retry_count_next = '0;
              end else begin
                phase_next      = sdspi_pkg::PH_DESEL;
                byte_count_next = sdspi_pkg::BC_W'(sdspi_pkg::ST_CMD_REJECTED);
              end
            end else begin
              if (rx_byte == 8'h00) begin
                phase_next = sdspi_pkg::PH_WTOKEN;
              end else begin
                phase_next      = sdspi_pkg::PH_DESEL;
                byte_count_next = sdspi_pkg::BC_W'(sdspi_pkg::ST_CMD_REJECTED);
              end
            end
          end
        end
        sdspi_pkg::PH_NEXT: begin
          card_address_next = '0;
          command_code_next = sdspi_pkg::CMD_SEND_OP;
          phase_next        = sdspi_pkg::PH_FRAME;
          byte_count_next   = '0;
        end
        sdspi_pkg::PH_TOKEN: begin
          last_response_next = rx_byte;
          retry_count_next   = retry_inc;
          if (rx_byte == start_token) begin
            phase_next      = sdspi_pkg::PH_RDATA;
            byte_count_next = '0;
          end else if (retry_inc >= token_wait_limit) begin
            phase_next      = sdspi_pkg::PH_DESEL;
            byte_count_next = sdspi_pkg::BC_W'(sdspi_pkg::ST_TOKEN_TIMEOUT);
          end
        end
        sdspi_pkg::PH_RDATA: begin
          read_byte       = rx_byte;
          read_valid      = 1'b1;
          byte_count_next = bc_inc;
          if (bc_inc >= sdspi_pkg::BC_W'(sdspi_pkg::SECTOR_BYTES)) begin
            phase_next      = sdspi_pkg::PH_RCRC;
            byte_count_next = '0;
          end
        end
        sdspi_pkg::PH_RCRC: begin
          byte_count_next = bc_inc;
          if (bc_inc >= sdspi_pkg::BC_W'(2)) begin
            phase_next      = sdspi_pkg::PH_DESEL;
            byte_count_next = sdspi_pkg::BC_W'(sdspi_pkg::ST_OK);
          end
        end
        sdspi_pkg::PH_WTOKEN: begin
          phase_next      = sdspi_pkg::PH_WDATA;
          byte_count_next = '0;
        end
        sdspi_pkg::PH_WDATA: begin
          byte_count_next = bc_inc;
          if (bc_inc >= sdspi_pkg::BC_W'(sdspi_pkg::SECTOR_BYTES)) begin
            phase_next      = sdspi_pkg::PH_WCRC;
            byte_count_next = '0;
          end
        end
        sdspi_pkg::PH_WCRC: begin
          byte_count_next = bc_inc;
          if (bc_inc >= sdspi_pkg::BC_W'(2)) begin
            phase_next = sdspi_pkg::PH_WRESP;
          end
        end
        sdspi_pkg::PH_WRESP: begin
          last_response_next = rx_byte;
          if (rx_byte[3:0] == accept_code) begin
            phase_next       = sdspi_pkg::PH_WBUSY;
            retry_count_next = '0;
          end else begin
            phase_next      = sdspi_pkg::PH_DESEL;
            byte_count_next = sdspi_pkg::BC_W'(sdspi_pkg::ST_DATA_REJECTED);
          end
        end
        sdspi_pkg::PH_WBUSY: begin
          last_response_next = rx_byte;
          retry_count_next   = retry_inc;
          if (rx_byte != 8'h00) begin
            phase_next      = sdspi_pkg::PH_DESEL;
            byte_count_next = sdspi_pkg::BC_W'(sdspi_pkg::ST_OK);
          end else if (retry_inc >= busy_wait_limit) begin
            phase_next      = sdspi_pkg::PH_DESEL;
            byte_count_next = sdspi_pkg::BC_W'(sdspi_pkg::ST_BUSY_TIMEOUT);
          end
        end
        sdspi_pkg::PH_DESEL: begin
          // byte counter carries the status during the final deselect
          status = byte_count[2:0];
          if (pending_op == sdspi_pkg::OP_INIT && status == sdspi_pkg::ST_OK) begin
            fast_mode_next = 1'b1;
          end
          done_res        = 1'b1;
          phase_next      = sdspi_pkg::PH_IDLE;
          byte_count_next = '0;
          pending_op_next = sdspi_pkg::OP_NONE;
        end
        default: begin
          phase_next      = sdspi_pkg::PH_IDLE;
          byte_count_next = '0;
          pending_op_next = sdspi_pkg::OP_NONE;
        end
      endcase
    end
  end

  // byte to send for the phase just entered
  always_comb begin
    tx_byte       = 8'h00;
    tx_valid      = 1'b0;
    card_selected = 1'b0;
    if (active && phase_next != sdspi_pkg::PH_IDLE) begin
      tx_valid      = 1'b1;
      card_selected = 1'b1;
      tx_byte       = sdspi_pkg::IDLE_BYTE;
      unique case (phase_next)
        sdspi_pkg::PH_WAKE, sdspi_pkg::PH_DESEL, sdspi_pkg::PH_NEXT: begin
          card_selected = 1'b0;
        end
        sdspi_pkg::PH_FRAME: begin
          unique case (byte_count_next[2:0])
            3'd0:    tx_byte = sdspi_pkg::CMD_PREFIX | {2'b00, command_code_next};
            3'd1:    tx_byte = card_address_next[31:24];
            3'd2:    tx_byte = card_address_next[23:16];
            3'd3:    tx_byte = card_address_next[15:8];
            3'd4:    tx_byte = card_address_next[7:0];
            default: tx_byte = sdspi_pkg::FRAME_CRC;
          endcase
        end
        sdspi_pkg::PH_WTOKEN: tx_byte = start_token;
        sdspi_pkg::PH_WDATA:  tx_byte = write_byte;
        default: ;
      endcase
    end
  end

  // sequencer state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= sdspi_pkg::PH_IDLE;
      byte_count    <= '0;
      retry_count   <= '0;
      card_address  <= '0;
      command_code  <= '0;
      last_response <= sdspi_pkg::IDLE_BYTE;
      fast_mode     <= 1'b0;
      pending_op    <= sdspi_pkg::OP_NONE;
    end else if (in_xfer) begin
      phase         <= phase_next;
      byte_count    <= byte_count_next;
      retry_count   <= retry_count_next;
      card_address  <= card_address_next;
      command_code  <= command_code_next;
      last_response <= last_response_next;
      fast_mode     <= fast_mode_next;
      pending_op    <= pending_op_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (in_xfer) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      m_tdata <= {last_response_next, status, done_res, read_valid, read_byte,
                  fast_mode_next, card_selected, tx_valid, tx_byte};
    end
  end

  // a finished request leaves no exchange pending
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[20] |-> !m_tdata[8])
    else $error("done result also asks for an exchange");

  // sector data is always followed by another exchange
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[19] |-> m_tdata[8] && m_tdata[9])
    else $error("read data without a following exchange");

  // fast clock is switched on only when a deselect completes
  assert property (@(posedge clk) disable iff (rst)
    $rose(fast_mode) |-> $past(phase) == sdspi_pkg::PH_DESEL)
    else $error("fast clock set outside final deselect");

  // idle phase leaves no count or pending operation behind
  assert property (@(posedge clk) disable iff (rst)
    phase == sdspi_pkg::PH_IDLE |-> byte_count == '0 && pending_op == sdspi_pkg::OP_NONE)
    else $error("idle with stale counter or pending op");

endmodule
